### rtl/core/kfet_pkg.sv
package kfet_pkg;

    localparam int TIME_W  = 32;
    localparam int VAL_W   = 17;
    localparam int KEY_W   = TIME_W + VAL_W;
    localparam int WIN_W   = 20;
    localparam int PROD_W  = TIME_W + VAL_W;
    localparam int QUO_W   = 17;
    localparam int OUT_CNT_W = 6;

    localparam logic [VAL_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [WIN_W-1:0] WINDOW_RST  = 20'd1000;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_DEL = 2'd1,
        ACT_QRY = 2'd2,
        ACT_NOP = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_UPD  = 2'd1,
        ST_FULL = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_EV,
        S_SH_RD,
        S_SH_EV,
        S_SH_INS,
        S_DEL_RD,
        S_DEL_EV,
        S_Q_RD,
        S_Q_EV,
        S_Q_LRD,
        S_Q_LEV,
        S_Q_MUL,
        S_Q_DST,
        S_Q_DIV,
        S_RESP
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/core/kfet_ram.sv
module kfet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/kfet_div.sv
module kfet_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [kfet_pkg::PROD_W-1:0]  num,
    input  logic [kfet_pkg::TIME_W-1:0]  den,
    output kfet_pkg::div_stat_t          stat,
    output logic [kfet_pkg::QUO_W-1:0]   quo
);
    import kfet_pkg::*;

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // restoring division, one quotient bit per cycle, msb first
    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            dsh_next  = PROD_W'({den, {(QUO_W-1){1'b0}}});
            quo_next  = '0;
            step_next = STEP_W'(QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= dsh_reg) begin
                rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without run");
    a_step_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && step_reg == '0) |-> 1'b0)
        else $error("divider step count underflow");

endmodule

### rtl/core/keyframe_envelope_table_unit.sv
// channel  dir  tdata (lsb up)                              tuser
// s_       in   track_index[3:0] time_us[35:4] new_value    action[1:0]
//               [53:36], zero pad [55:54]
// m_       out  result_value[16:0] keys_in_track[22:17],     status[1:0]
//               zero pad [23]
// cfg_     in   match_window on cfg_wr_data, write on cfg_wr_en
//
// One word at a time; the key RAM has one read port and each key visit
// takes a read state plus an evaluate state.
// Add: scan for a near key, then shift later keys and insert. Delete: scan of all keys.
// Query: scan up to the segment, last-key check, multiply, then the divider.
// Synchronous active-low reset clears key counts and sets the window to 1000 us.
// s_tready is high only when idle; a waiting result blocks the next one.
module keyframe_envelope_table_unit #(
    parameter int NUM_TRACKS = 16,
    parameter int MAX_KEYS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // track_index, time_us, new_value
    input  logic [1:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // result_value, keys_in_track
    output logic [1:0]  m_tuser,  // status
    input  logic        cfg_wr_en,
    input  logic [kfet_pkg::WIN_W-1:0] cfg_wr_data
);
    import kfet_pkg::*;

    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int IW    = $clog2(MAX_KEYS);
    localparam int DEPTH = NUM_TRACKS * MAX_KEYS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

    state_t state_reg, state_next;

    logic [WIN_W-1:0]  window_reg;
    logic [CW-1:0]     counts_reg [NUM_TRACKS];

    action_t           act_reg, act_next;
    logic [3:0]        trk_reg, trk_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [VAL_W-1:0]  v_reg, v_next;
    logic              vld_reg, vld_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     w_reg, w_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [KEY_W-1:0]  prev_reg, prev_next;
    logic [TIME_W-1:0] off_reg, off_next;
    logic [TIME_W-1:0] span_reg, span_next;
    logic [VAL_W-1:0]  diff_reg, diff_next;
    logic              up_reg, up_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0]  res_reg, res_next;
    status_t           st_reg, st_next;

    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_res_reg, m_res_next;
    status_t           m_st_reg, m_st_next;
    logic [OUT_CNT_W-1:0] m_cnt_reg, m_cnt_next;

    logic              cnt_we;
    logic [CW-1:0]     cnt_wval;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [KEY_W-1:0]  ram_wdata, ram_rdata;

    logic              div_start;
    div_stat_t         div_stat;
    logic [QUO_W-1:0]  div_quo;

    logic              accept;
    logic [TW+3:0]     trk_w;
    logic [TW-1:0]     trk_sel;
    logic [AW-1:0]     base;
    logic [TIME_W-1:0] rt;
    logic [VAL_W-1:0]  rv;
    logic [TIME_W-1:0] tdiff;
    logic              near;
    logic [CW-1:0]     pos_m1;
    logic [CW-1:0]     n_m1;
    logic [17:0]       in_val;
    logic [VAL_W-1:0]  in_clamp;
    logic [3:0]        in_trk;
    logic [CW+OUT_CNT_W-1:0] cnt_ext;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    assign trk_w   = {{TW{1'b0}}, trk_reg};
    assign trk_sel = trk_w[TW-1:0];
    assign base    = AW'(32'(trk_reg) * MAX_KEYS);
    assign rt      = ram_rdata[KEY_W-1:VAL_W];
    assign rv      = ram_rdata[VAL_W-1:0];
    assign tdiff   = (rt >= t_reg) ? (rt - t_reg) : (t_reg - rt);
    assign near    = tdiff < {{(TIME_W-WIN_W){1'b0}}, window_reg};
    assign pos_m1  = pos_reg - CW'(1);
    assign n_m1    = n_reg - CW'(1);

    assign in_trk   = s_tdata[3:0];
    assign in_val   = s_tdata[53:36];
    assign in_clamp = in_val[17] ? '0 :
                      (in_val[16:0] > ONE_Q16) ? ONE_Q16 : in_val[16:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (action_t'(s_tuser))
                        ACT_ADD: state_next = (32'(in_trk) < NUM_TRACKS) ? S_ADD_RD : S_RESP;
                        ACT_DEL: state_next = (32'(in_trk) < NUM_TRACKS) ? S_DEL_RD : S_RESP;
                        ACT_QRY: state_next = S_Q_RD;
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_ADD_RD: begin
                if (idx_reg == n_reg) begin
                    if (n_reg >= CW'(MAX_KEYS)) begin
                        state_next = S_RESP;
                    end else if (n_reg == '0) begin
                        state_next = S_SH_INS;
                    end else begin
                        state_next = S_SH_RD;
                    end
                end else begin
                    state_next = S_ADD_EV;
                end
            end
            S_ADD_EV: state_next = near ? S_RESP : S_ADD_RD;
            S_SH_RD:  state_next = S_SH_EV;
            S_SH_EV: begin
                if (rt > t_reg) begin
                    state_next = (pos_reg == CW'(1)) ? S_SH_INS : S_SH_RD;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_SH_INS: state_next = S_RESP;
            S_DEL_RD: state_next = (idx_reg == n_reg) ? S_RESP : S_DEL_EV;
            S_DEL_EV: state_next = S_DEL_RD;
            S_Q_RD: begin
                if (!vld_reg || n_reg == '0 || idx_reg == n_reg) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_Q_EV;
                end
            end
            S_Q_EV: begin
                if (idx_reg == '0) begin
                    state_next = (t_reg <= rt) ? S_RESP : S_Q_LRD;
                end else begin
                    state_next = (rt >= t_reg) ? S_Q_MUL : S_Q_RD;
                end
            end
            S_Q_LRD: state_next = S_Q_LEV;
            S_Q_LEV: state_next = (t_reg >= rt) ? S_RESP : S_Q_RD;
            S_Q_MUL: state_next = S_Q_DST;
            S_Q_DST: state_next = S_Q_DIV;
            S_Q_DIV: state_next = div_stat.done ? S_RESP : S_Q_DIV;
            S_RESP:  state_next = (!m_valid_reg || m_tready) ? S_IDLE : S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        act_next  = act_reg;
        trk_next  = trk_reg;
        t_next    = t_reg;
        v_next    = v_reg;
        vld_next  = vld_reg;
        n_next    = n_reg;
        idx_next  = idx_reg;
        w_next    = w_reg;
        pos_next  = pos_reg;
        prev_next = prev_reg;
        off_next  = off_reg;
        span_next = span_reg;
        diff_next = diff_reg;
        up_next   = up_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        st_next   = st_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_st_next    = m_st_reg;
        m_cnt_next   = m_cnt_reg;
        cnt_we    = 1'b0;
        cnt_wval  = n_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = base + AW'(pos_reg[IW-1:0]);
        ram_raddr = base + AW'(idx_reg[IW-1:0]);
        ram_wdata = {t_reg, v_reg};
        div_start = 1'b0;
        cnt_ext   = {{OUT_CNT_W{1'b0}}, counts_reg[trk_sel]};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    act_next = action_t'(s_tuser);
                    trk_next = in_trk;
                    t_next   = s_tdata[35:4];
                    v_next   = in_clamp;
                    vld_next = 32'(in_trk) < NUM_TRACKS;
                    n_next   = (32'(in_trk) < NUM_TRACKS) ?
                               counts_reg[TW'({{TW{1'b0}}, in_trk})] : '0;
                    idx_next = '0;
                    w_next   = '0;
                    res_next = '0;
                    unique case (action_t'(s_tuser))
                        ACT_ADD: st_next = ST_FULL;
                        ACT_QRY: begin
                            st_next  = ST_NONE;
                            res_next = ONE_Q16;
                        end
                        default: st_next = ST_NONE;
                    endcase
                end
            end
            S_ADD_RD: begin
                if (idx_reg == n_reg) begin
                    pos_next = n_reg;
                    if (n_reg >= CW'(MAX_KEYS)) begin
                        st_next = ST_FULL;
                    end
                end else begin
                    ram_re = 1'b1;
                end
            end
            S_ADD_EV: begin
                if (near) begin
                    ram_we    = 1'b1;
                    ram_waddr = base + AW'(idx_reg[IW-1:0]);
                    ram_wdata = {rt, v_reg};
                    st_next   = ST_UPD;
                end
                idx_next = idx_reg + CW'(1);
            end
            S_SH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = base + AW'(pos_m1[IW-1:0]);
            end
            S_SH_EV: begin
                ram_we = 1'b1;
                if (rt > t_reg) begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_m1;
                end else begin
                    cnt_we   = 1'b1;
                    cnt_wval = n_reg + CW'(1);
                    st_next  = ST_DONE;
                end
            end
            S_SH_INS: begin
                ram_we   = 1'b1;
                cnt_we   = 1'b1;
                cnt_wval = n_reg + CW'(1);
                st_next  = ST_DONE;
            end
            S_DEL_RD: begin
                if (idx_reg == n_reg) begin
                    cnt_we   = 1'b1;
                    cnt_wval = w_reg;
                    st_next  = (w_reg == n_reg) ? ST_NONE : ST_DONE;
                end else begin
                    ram_re = 1'b1;
                end
            end
            S_DEL_EV: begin
                if (!near) begin
                    ram_we    = 1'b1;
                    ram_waddr = base + AW'(w_reg[IW-1:0]);
                    ram_wdata = ram_rdata;
                    w_next    = w_reg + CW'(1);
                end
                idx_next = idx_reg + CW'(1);
            end
            S_Q_RD: begin
                if (vld_reg && n_reg != '0) begin
                    if (idx_reg == n_reg) begin
                        // past the last key: hold its value
                        res_next = prev_reg[VAL_W-1:0];
                        st_next  = ST_DONE;
                    end else begin
                        ram_re = 1'b1;
                    end
                end
            end
            S_Q_EV: begin
                prev_next = ram_rdata;
                idx_next  = idx_reg + CW'(1);
                if (idx_reg == '0) begin
                    if (t_reg <= rt) begin
                        res_next = rv;
                        st_next  = ST_DONE;
                    end
                end else begin
                    off_next  = t_reg - prev_reg[KEY_W-1:VAL_W];
                    span_next = rt - prev_reg[KEY_W-1:VAL_W];
                    up_next   = rv >= prev_reg[VAL_W-1:0];
                    diff_next = (rv >= prev_reg[VAL_W-1:0]) ?
                                (rv - prev_reg[VAL_W-1:0]) : (prev_reg[VAL_W-1:0] - rv);
                    if (rt >= t_reg) begin
                        prev_next = prev_reg;
                    end
                end
            end
            // at or past the last key: its value wins, even over equal-time neighbors
            S_Q_LRD: begin
                ram_re    = 1'b1;
                ram_raddr = base + AW'(n_m1[IW-1:0]);
            end
            S_Q_LEV: begin
                if (t_reg >= rt) begin
                    res_next = rv;
                    st_next  = ST_DONE;
                end
            end
            S_Q_MUL: prod_next = PROD_W'(off_reg) * PROD_W'(diff_reg);
            S_Q_DST: div_start = 1'b1;
            S_Q_DIV: begin
                if (div_stat.done) begin
                    res_next = up_reg ? (prev_reg[VAL_W-1:0] + div_quo) :
                                        (prev_reg[VAL_W-1:0] - div_quo);
                    st_next  = ST_DONE;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    m_st_next    = st_reg;
                    m_cnt_next   = vld_reg ? cnt_ext[OUT_CNT_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            window_reg  <= WINDOW_RST;
            for (int i = 0; i < NUM_TRACKS; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
            end
            if (cnt_we) begin
                counts_reg[trk_sel] <= cnt_wval;
            end
        end
        act_reg  <= act_next;
        trk_reg  <= trk_next;
        t_reg    <= t_next;
        v_reg    <= v_next;
        vld_reg  <= vld_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        w_reg    <= w_next;
        pos_reg  <= pos_next;
        prev_reg <= prev_next;
        off_reg  <= off_next;
        span_reg <= span_next;
        diff_reg <= diff_next;
        up_reg   <= up_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        m_res_reg <= m_res_next;
        m_st_reg  <= m_st_next;
        m_cnt_reg <= m_cnt_next;
    end

    kfet_ram #(
        .WIDTH(KEY_W),
        .DEPTH(DEPTH)
    ) u_keys (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    kfet_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (prod_reg),
        .den    (span_reg),
        .stat   (div_stat),
        .quo    (div_quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_cnt_reg, m_res_reg};
    assign m_tuser  = m_st_reg;

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("key write while idle");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> (cnt_wval <= CW'(MAX_KEYS)))
        else $error("key count beyond capacity");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("word accepted without work");
    a_act_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && $past(state_reg) != S_IDLE) |-> $stable(act_reg))
        else $error("action changed mid-item");

endmodule
